### rtl/core/jkv_pkg.sv
// Shared constants, types and codes for the JSON key/value extractor.
package jkv_pkg;

   // Key window sizing.
   localparam int MAX_KEY_BYTES = 32;
   localparam int WIN_DEPTH     = MAX_KEY_BYTES + 2;
   localparam int KEY_LEN_W     = 6;
   localparam int KEY_IDX_W     = 5;
   localparam int KEY_BITS      = MAX_KEY_BYTES * 8;
   localparam int WIN_IDX_W     = 6;

   // Output buffer limits.
   localparam int MAX_OUT_CAPACITY = 4096;
   localparam int CAP_W            = 13;
   localparam int COUNT_W          = 12;

   // Integer parsing limits.
   localparam logic [63:0] MAG_LIMIT      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAG_LIMIT_DIV10 = MAG_LIMIT / 64'd10;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Character codes.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_SKIP,
      PH_INT_WS,
      PH_INT_NUM,
      PH_STR,
      PH_STR_ESC,
      PH_DONE
   } phase_type;

   // Final status codes.
   typedef enum logic [2:0] {
      ST_OK,
      ST_NO_KEY,
      ST_NOT_STRING,
      ST_NO_DIGITS,
      ST_FULL
   } status_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_VALUE_KIND,
      CSR_OUT_CAPACITY,
      CSR_KEY_LENGTH,
      CSR_KEY_0_7,
      CSR_KEY_8_15,
      CSR_KEY_16_23,
      CSR_KEY_24_31
   } csr_index_type;

   // Parser configuration.
   typedef struct packed {
      logic                 value_kind;
      logic [CAP_W-1:0]     out_capacity;
   } cfg_type;

   // One result word.
   typedef struct packed {
      logic [7:0]         value_char;
      logic               char_valid;
      logic               is_final;
      logic [2:0]         status;
      logic [COUNT_W-1:0] value_length;
      logic signed [63:0] int_value;
   } rsp_word_type;

   // Up to two result words produced by one document byte, character first.
   typedef struct packed {
      logic         char_push;
      rsp_word_type char_word;
      logic         final_push;
      rsp_word_type final_word;
   } push_type;

endpackage

### rtl/core/jkv_window.sv
// Sliding window of recent document bytes and the quoted key compare.
module jkv_window (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift,
   input  logic                            clear,
   input  logic [7:0]                      byte_in,
   input  logic [jkv_pkg::KEY_LEN_W-1:0]   key_length,
   input  logic [jkv_pkg::KEY_BITS-1:0]    key_vec,
   output logic                            key_hit
);
   import jkv_pkg::*;

   logic [7:0]           recent_ff [WIN_DEPTH];
   logic [7:0]           recent_in [WIN_DEPTH];
   logic [7:0]           win       [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] quote_at;
   logic [KEY_LEN_W-1:0] len;
   logic [WIN_IDX_W-1:0] close_idx;
   logic [MAX_KEY_BYTES:1] byte_ok;
   logic [KEY_LEN_W-1:0] rel_idx [1:MAX_KEY_BYTES];

   // The window as it looks with the new byte shifted in at the front.
   always_comb begin
      win[0] = byte_in;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   // Key lengths beyond the window are clamped.
   assign len = (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ? KEY_LEN_W'(MAX_KEY_BYTES)
                                                         : key_length;
   assign close_idx = WIN_IDX_W'(len) + WIN_IDX_W'(1);

   // Quote detection at every tap; the opening quote is picked by the key length.
   always_comb begin
      for (int p = 0; p < WIN_DEPTH; p++) begin
         quote_at[p] = (win[p] == CH_QUOTE);
      end
   end

   // Tap i holds key byte len-i, newest byte being the last key byte.
   always_comb begin
      for (int i = 1; i <= MAX_KEY_BYTES; i++) begin
         rel_idx[i] = len - KEY_LEN_W'(i);
         byte_ok[i] = (KEY_LEN_W'(i) > len) ||
                      (win[i] == key_vec[KEY_IDX_W'(rel_idx[i]) * 8 +: 8]);
      end
   end

   assign key_hit = quote_at[0] && quote_at[close_idx] && (&byte_ok);

   // Shift line next value.
   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (clear) begin
            recent_in[k] = '0;
         end else if (shift) begin
            recent_in[k] = win[k];
         end else begin
            recent_in[k] = recent_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (reset) begin
            recent_ff[k] <= '0;
         end else begin
            recent_ff[k] <= recent_in[k];
         end
      end
   end

endmodule

### rtl/core/jkv_parse.sv
// Value parser: phase control, string unescape, decimal accumulate and result words.
module jkv_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        doc_byte,
   input  logic              doc_last,
   input  jkv_pkg::cfg_type  cfg,
   input  logic              key_hit,
   output logic              win_shift,
   output logic              win_clear,
   output jkv_pkg::push_type push
);
   import jkv_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               dseen_ff, dseen_in;

   phase_type          ph_a;
   logic [COUNT_W-1:0] cnt_a;
   logic [63:0]        mag_a;
   logic               neg_a;
   logic               dseen_a;
   logic               shift_a;
   logic               creq;
   logic               char_emit;
   logic [7:0]         cbyte;
   logic               fin;
   status_type         fst;
   logic               fint;
   logic               int_go;

   logic               proc;
   logic               end_doc;
   logic               is_ws;
   logic               is_sep;
   logic               is_digit;
   logic [CAP_W-1:0]   cap;
   logic               full;
   logic [63:0]        m10;
   logic [64:0]        sum;
   logic [63:0]        mag_step;
   logic [63:0]        int_sat;

   // Byte classes.
   assign is_ws    = (doc_byte == CH_SPACE) || (doc_byte == CH_TAB) || (doc_byte == CH_LF) ||
                     (doc_byte == CH_VT) || (doc_byte == CH_FF) || (doc_byte == CH_CR);
   assign is_sep   = (doc_byte == CH_SPACE) || (doc_byte == CH_TAB) || (doc_byte == CH_COLON);
   assign is_digit = (doc_byte >= CH_ZERO) && (doc_byte <= CH_NINE);
   assign proc     = (phase_ff != PH_DONE) && (doc_byte != CH_NUL);
   assign end_doc  = (doc_byte == CH_NUL) || doc_last;

   // Capacity check: the next character must leave room for the terminator.
   assign cap  = (cfg.out_capacity > CAP_W'(MAX_OUT_CAPACITY)) ? CAP_W'(MAX_OUT_CAPACITY)
                                                                : cfg.out_capacity;
   assign full = ({1'b0, cnt_ff} + CAP_W'(1)) >= cap;

   // One decimal step, saturating at the magnitude limit.
   assign m10 = (mag_ff << 3) + (mag_ff << 1);
   assign sum = {1'b0, m10} + 65'(doc_byte[3:0]);
   always_comb begin
      if (mag_ff > MAG_LIMIT_DIV10) begin
         mag_step = MAG_LIMIT;
      end else if (sum > {1'b0, MAG_LIMIT}) begin
         mag_step = MAG_LIMIT;
      end else begin
         mag_step = sum[63:0];
      end
   end

   // Decode the byte against the current phase, then apply end of document.
   always_comb begin
      ph_a    = phase_ff;
      cnt_a   = cnt_ff;
      mag_a   = mag_ff;
      neg_a   = neg_ff;
      dseen_a = dseen_ff;
      shift_a = 1'b0;
      creq    = 1'b0;
      cbyte   = doc_byte;
      fin     = 1'b0;
      fst     = ST_OK;
      fint    = 1'b0;
      int_go  = 1'b0;
      char_emit = 1'b0;
      if (proc) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               shift_a = 1'b1;
               if (key_hit) begin
                  ph_a = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (is_sep) begin
                  ph_a = PH_SKIP;
               end else if (cfg.value_kind) begin
                  int_go = 1'b1;
               end else if (doc_byte == CH_QUOTE) begin
                  ph_a = PH_STR;
               end else begin
                  fin = 1'b1;
                  fst = ST_NOT_STRING;
               end
            end
            PH_INT_WS: begin
               int_go = 1'b1;
            end
            PH_INT_NUM: begin
               if (is_digit) begin
                  mag_a   = mag_step;
                  dseen_a = 1'b1;
               end else if (dseen_ff) begin
                  fin  = 1'b1;
                  fint = 1'b1;
               end else begin
                  fin = 1'b1;
                  fst = ST_NO_DIGITS;
               end
            end
            PH_STR: begin
               if (doc_byte == CH_QUOTE) begin
                  fin = 1'b1;
               end else if (doc_byte == CH_BSLASH) begin
                  ph_a = PH_STR_ESC;
               end else begin
                  creq = 1'b1;
               end
            end
            PH_STR_ESC: begin
               ph_a = PH_STR;
               creq = 1'b1;
               if (doc_byte == CH_LOW_N) begin
                  cbyte = CH_LF;
               end else if (doc_byte == CH_LOW_R) begin
                  cbyte = CH_CR;
               end else if (doc_byte == CH_LOW_T) begin
                  cbyte = CH_TAB;
               end
            end
            default: begin
               ph_a = phase_ff;
            end
         endcase
      end

      // Start of a signed decimal: whitespace, sign or first digit.
      if (int_go) begin
         if (is_ws) begin
            ph_a = PH_INT_WS;
         end else if (doc_byte == CH_PLUS) begin
            ph_a = PH_INT_NUM;
         end else if (doc_byte == CH_MINUS) begin
            neg_a = 1'b1;
            ph_a  = PH_INT_NUM;
         end else if (is_digit) begin
            mag_a   = mag_step;
            dseen_a = 1'b1;
            ph_a    = PH_INT_NUM;
         end else begin
            fin = 1'b1;
            fst = ST_NO_DIGITS;
         end
      end
      if (fin) begin
         ph_a = PH_DONE;
      end

      // A backslash left open at the end of the document is taken literally.
      if (end_doc && (ph_a == PH_STR_ESC)) begin
         creq  = 1'b1;
         cbyte = CH_BSLASH;
         ph_a  = PH_STR;
      end

      // Deliver the character or close with an output-full status.
      if (creq) begin
         if (full) begin
            fin  = 1'b1;
            fst  = ST_FULL;
            ph_a = PH_DONE;
         end else begin
            char_emit = 1'b1;
            cnt_a     = cnt_ff + COUNT_W'(1);
         end
      end

      // End of document closes whatever is still open.
      if (end_doc && (ph_a != PH_DONE)) begin
         fin = 1'b1;
         unique case (ph_a)
            PH_SEARCH:  fst = ST_NO_KEY;
            PH_SKIP:    fst = cfg.value_kind ? ST_NO_DIGITS : ST_NOT_STRING;
            PH_INT_WS:  fst = ST_NO_DIGITS;
            PH_INT_NUM: begin
               if (dseen_a) begin
                  fint = 1'b1;
               end else begin
                  fst = ST_NO_DIGITS;
               end
            end
            default:    fst = ST_OK;
         endcase
         ph_a = PH_DONE;
      end
   end

   // Saturated signed value of the accumulated magnitude.
   always_comb begin
      if (neg_a) begin
         int_sat = (mag_a >= MAG_LIMIT) ? MAG_LIMIT : (~mag_a + 64'd1);
      end else begin
         int_sat = (mag_a >= MAG_LIMIT) ? (MAG_LIMIT - 64'd1) : mag_a;
      end
   end

   // Next state: a last byte rearms for a new document.
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      dseen_in = dseen_ff;
      if (fire) begin
         if (doc_last) begin
            phase_in = PH_SEARCH;
            cnt_in   = '0;
            mag_in   = '0;
            neg_in   = 1'b0;
            dseen_in = 1'b0;
         end else begin
            phase_in = ph_a;
            cnt_in   = cnt_a;
            mag_in   = mag_a;
            neg_in   = neg_a;
            dseen_in = dseen_a;
         end
      end
   end

   // Outputs: window control and the result words of this byte.
   always_comb begin
      win_shift = fire && shift_a;
      win_clear = fire && doc_last;

      push.char_push               = fire && char_emit;
      push.char_word.value_char    = cbyte;
      push.char_word.char_valid    = 1'b1;
      push.char_word.is_final      = 1'b0;
      push.char_word.status        = ST_OK;
      push.char_word.value_length  = '0;
      push.char_word.int_value     = '0;

      push.final_push              = fire && fin;
      push.final_word.value_char   = CH_NUL;
      push.final_word.char_valid   = 1'b0;
      push.final_word.is_final     = 1'b1;
      push.final_word.status       = fst;
      push.final_word.value_length = cfg.value_kind ? '0 : cnt_a;
      push.final_word.int_value    = fint ? int_sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         cnt_ff   <= '0;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         dseen_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         dseen_ff <= dseen_in;
      end
   end

endmodule

### rtl/core/jkv_rsp_fifo.sv
// Small result queue that takes up to two words per cycle and hands out one.
module jkv_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  jkv_pkg::push_type     push,
   output logic                  has_room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output jkv_pkg::rsp_word_type rsp_word
);
   import jkv_pkg::*;

   rsp_word_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_second;
   logic                  pop;

   // Room for a full pair of words is judged from registered state only.
   assign has_room  = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // The final word lands behind the character word when both come at once.
   assign wr_second = wr_ptr_ff + FIFO_PTR_W'(push.char_push);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.char_push) + FIFO_PTR_W'(push.final_push);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.char_push) + FIFO_CNT_W'(push.final_push)
                  - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push.char_push) begin
         mem_ff[wr_ptr_ff] <= push.char_word;
      end
      if (push.final_push) begin
         mem_ff[wr_second] <= push.final_word;
      end
   end

endmodule

### rtl/core/json_key_value_extractor_unit.sv
// Top level of the streaming JSON key/value extractor.
//
// The req channel takes one document byte per word with a last flag; a zero
// byte also ends the document. The rsp channel returns decoded string
// characters (char_valid set) and exactly one closing word per document
// (is_final set) with the status, the character count and, in integer mode,
// the saturated value. The csr port writes value_kind, out_capacity,
// key_length and the four key byte registers by index, with no wait.
// A byte accepted into the input register is decoded from there into a
// four-word result queue once the queue has room; its words are then read
// from the queue. One byte is accepted every cycle while the queue holds at
// most two words; a byte that yields a character and the closing word
// together takes one queue slot more. While the receiver does not stall,
// one byte per cycle is sustained, set by the combinational window compare
// and decimal step. Reset clears the window, parser state and queue and
// loads the register defaults. When the receiver stalls, the queue fills
// and req_stall rises until words drain; nothing is dropped.
module json_key_value_extractor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_doc_byte,
   input  logic               req_doc_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_value_char,
   output logic               rsp_char_valid,
   output logic               rsp_is_final,
   output logic [2:0]         rsp_status,
   output logic [11:0]        rsp_value_length,
   output logic signed [63:0] rsp_int_value,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import jkv_pkg::*;

   logic                 value_kind_ff;
   logic [CAP_W-1:0]     out_capacity_ff;
   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [63:0]          key_words_ff [4];

   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;

   logic                 req_take;
   logic                 fire;
   logic                 has_room;
   logic                 key_hit;
   logic                 win_shift;
   logic                 win_clear;
   logic [KEY_BITS-1:0]  key_vec;
   cfg_type              cfg;
   push_type             push;
   rsp_word_type         rsp_word;
   csr_index_type        csr_sel;

   // Configuration registers.
   assign csr_sel = csr_index_type'(csr_index);
   always_ff @(posedge clock) begin
      if (reset) begin
         value_kind_ff   <= 1'b0;
         out_capacity_ff <= CAP_W'(256);
         key_length_ff   <= KEY_LEN_W'(1);
         for (int w = 0; w < 4; w++) begin
            key_words_ff[w] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_sel)
            CSR_VALUE_KIND:   value_kind_ff   <= csr_wdata[0];
            CSR_OUT_CAPACITY: out_capacity_ff <= csr_wdata[CAP_W-1:0];
            CSR_KEY_LENGTH:   key_length_ff   <= csr_wdata[KEY_LEN_W-1:0];
            CSR_KEY_0_7:      key_words_ff[0] <= csr_wdata;
            CSR_KEY_8_15:     key_words_ff[1] <= csr_wdata;
            CSR_KEY_16_23:    key_words_ff[2] <= csr_wdata;
            CSR_KEY_24_31:    key_words_ff[3] <= csr_wdata;
            default:          value_kind_ff   <= value_kind_ff;
         endcase
      end
   end

   assign key_vec = {key_words_ff[3], key_words_ff[2], key_words_ff[1], key_words_ff[0]};
   assign cfg.value_kind   = value_kind_ff;
   assign cfg.out_capacity = out_capacity_ff;

   // Input register: the held byte is decoded once the queue has room.
   assign fire      = in_vld_ff && has_room;
   assign req_stall = in_vld_ff && !has_room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_doc_byte;
         in_last_ff <= req_doc_last;
      end
   end

   // Key window.
   jkv_window u_window (
      .clock      (clock),
      .reset      (reset),
      .shift      (win_shift),
      .clear      (win_clear),
      .byte_in    (in_byte_ff),
      .key_length (key_length_ff),
      .key_vec    (key_vec),
      .key_hit    (key_hit)
   );

   // Value parser.
   jkv_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .doc_byte  (in_byte_ff),
      .doc_last  (in_last_ff),
      .cfg       (cfg),
      .key_hit   (key_hit),
      .win_shift (win_shift),
      .win_clear (win_clear),
      .push      (push)
   );

   // Result queue.
   jkv_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_value_char   = rsp_word.value_char;
   assign rsp_char_valid   = rsp_word.char_valid;
   assign rsp_is_final     = rsp_word.is_final;
   assign rsp_status       = rsp_word.status;
   assign rsp_value_length = rsp_word.value_length;
   assign rsp_int_value    = rsp_word.int_value;

endmodule
